@@ rtl/hsn_pkg.sv @@
// ----------------------------------------------------------------------------
// hsn_pkg
// Shared types and constants of the smoothed heightmap normal block.
// ----------------------------------------------------------------------------
package hsn_pkg;

  // Q1.14 value of one.
  localparam logic signed [15:0] UNIT_Q14 = 16'sd16384;

  // Configuration register indexes.
  localparam logic CFG_GRID_SIZE    = 1'b0;
  localparam logic CFG_GRID_SPACING = 1'b1;

  // Accumulated vertex normal, 18-bit signed components.
  typedef struct packed {
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic signed [17:0] z;
  } vec18_t;

  // Unit normal in Q1.14.
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } vec16_t;

  // One line store entry: height of the row above and the normal sum.
  typedef struct packed {
    logic signed [15:0] height;
    vec18_t             sum;
  } line_entry_t;

  // Widen a unit normal for accumulation.
  function automatic vec18_t widen(input vec16_t v);
    vec18_t w;
    w.x = 18'(v.x);
    w.y = 18'(v.y);
    w.z = 18'(v.z);
    return w;
  endfunction

  // Component-wise sum.
  function automatic vec18_t add_vec(input vec18_t a, input vec18_t b);
    vec18_t s;
    s.x = a.x + b.x;
    s.y = a.y + b.y;
    s.z = a.z + b.z;
    return s;
  endfunction

endpackage

@@ rtl/hsn_ram.sv @@
// ----------------------------------------------------------------------------
// hsn_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module hsn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/hsn_norm.sv @@
// ----------------------------------------------------------------------------
// hsn_norm
// Sequential vector normalizer: squared length with one multiplier, bit-serial
// square root, then a restoring divider for each component. Result is Q1.14,
// rounded half away from zero, saturated to one; zero length gives (0,1,0).
// ----------------------------------------------------------------------------
module hsn_norm
  import hsn_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  vec18_t vec_in,
  output logic   done,
  output vec16_t vec_out
);

  typedef enum logic [2:0] {
    N_IDLE, N_SQ, N_CHK, N_ROOT, N_DIV, N_DONE
  } nstate_t;

  nstate_t            state;
  vec18_t             vec;
  logic [1:0]         k;
  logic [3:0]         cnt;
  logic [37:0]        acc;
  logic [63:0]        rad;
  logic [63:0]        root;
  logic [63:0]        bitv;
  logic [31:0]        q;
  logic [31:0]        rem;
  logic [15:0]        quot;

  logic signed [17:0] comp;
  logic [17:0]        mag;
  logic [35:0]        sq;
  logic [63:0]        trial;
  logic [32:0]        rem2;
  logic               take;
  logic [15:0]        quot_fin;
  logic [16:0]        rounded;
  logic [15:0]        sat;
  logic signed [15:0] res;

  // Component selected by the index and its magnitude.
  always_comb begin
    case (k)
      2'd0:    comp = vec.x;
      2'd1:    comp = vec.y;
      default: comp = vec.z;
    endcase
    mag = comp[17] ? 18'(-comp) : 18'(comp);
  end

  assign sq = mag * mag;

  // One square root step and one division step.
  assign trial    = root + bitv;
  assign rem2     = {rem, 1'b0};
  assign take     = rem2 >= {1'b0, q};
  assign quot_fin = {quot[14:0], take};
  assign rounded  = ({1'b0, quot_fin} + 17'd1) >> 1;
  assign sat      = (rounded > 17'd16384) ? 16'd16384 : rounded[15:0];
  assign res      = comp[17] ? -$signed(sat) : $signed(sat);

  assign done = state == N_DONE;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
    end else begin
      case (state)
        N_IDLE: begin
          if (start) begin
            vec   <= vec_in;
            k     <= 2'd0;
            acc   <= '0;
            state <= N_SQ;
          end
        end
        N_SQ: begin
          acc <= acc + 38'(sq);
          if (k == 2'd2) begin
            state <= N_CHK;
          end else begin
            k <= k + 2'd1;
          end
        end
        N_CHK: begin
          if (acc == '0) begin
            vec_out.x <= '0;
            vec_out.y <= UNIT_Q14;
            vec_out.z <= '0;
            state     <= N_DONE;
          end else begin
            rad   <= {acc, 26'd0};
            root  <= '0;
            bitv  <= 64'd1 << 62;
            state <= N_ROOT;
          end
        end
        N_ROOT: begin
          if (bitv == '0) begin
            q     <= root[31:0];
            k     <= 2'd0;
            cnt   <= '0;
            quot  <= '0;
            rem   <= {2'b00, vec.x[17] ? 18'(-vec.x) : 18'(vec.x), 12'd0};
            state <= N_DIV;
          end else begin
            if (rad >= trial) begin
              rad  <= rad - trial;
              root <= (root >> 1) + bitv;
            end else begin
              root <= root >> 1;
            end
            bitv <= bitv >> 2;
          end
        end
        N_DIV: begin
          rem  <= take ? 32'(rem2 - {1'b0, q}) : rem2[31:0];
          quot <= quot_fin;
          cnt  <= cnt + 4'd1;
          if (cnt == 4'd15) begin
            case (k)
              2'd0:    vec_out.x <= res;
              2'd1:    vec_out.y <= res;
              default: vec_out.z <= res;
            endcase
            quot <= '0;
            if (k == 2'd2) begin
              state <= N_DONE;
            end else begin
              k <= k + 2'd1;
              if (k == 2'd0) begin
                rem <= {2'b00, vec.y[17] ? 18'(-vec.y) : 18'(vec.y), 12'd0};
              end else begin
                rem <= {2'b00, vec.z[17] ? 18'(-vec.z) : 18'(vec.z), 12'd0};
              end
            end
          end
        end
        N_DONE: begin
          state <= N_IDLE;
        end
        default: state <= N_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/heightmap_smooth_normals.sv @@
// ----------------------------------------------------------------------------
// heightmap_smooth_normals
// Smoothed vertex normals of a square height grid streamed in raster order.
// ----------------------------------------------------------------------------
// Heights enter one word at a time in raster order; each vertex normal leaves
// as soon as every cell touching it has been seen, up to four per input word,
// with tlast on the final one of that word. The block works on one height at
// a time. Each word past the first column reads two entries of a line store
// and writes two back; a word that completes a cell then runs one shared
// normalizer for two triangle normals, unless the spacing is zero, and for
// every emitted vertex. One normalization is a squaring pass over the three
// components, the square root steps and 48 divider steps. The line store
// needs no clearing pass.
// ----------------------------------------------------------------------------
module heightmap_smooth_normals
  import hsn_pkg::*;
#(
  parameter int GRID_MAX = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // height
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // vertex_row, vertex_col, normal_x, normal_y, normal_z
  output logic        m_tlast    // last
);

  localparam int CW = $clog2(GRID_MAX);
  localparam int GW = CW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_RD1, S_RD2, S_TRI, S_N1W, S_N2S, S_N2W, S_SUM,
    S_WR0, S_WR1, S_EM_SEL, S_EM_WAIT, S_EM_OUT, S_FIN
  } state_t;

  state_t             state;
  logic [8:0]         side_len;
  logic [15:0]        grid_spacing;
  logic [CW-1:0]      row_count;
  logic [CW-1:0]      col_count;
  logic signed [15:0] left_height;
  logic signed [15:0] h;
  logic [CW-1:0]      r;
  logic [CW-1:0]      c;
  line_entry_t        d0;
  line_entry_t        d1;
  vec16_t             n1;
  vec16_t             n2;
  vec18_t             lower;
  vec18_t             tl;
  vec18_t             tr;
  vec18_t             bl;
  vec18_t             br;
  logic [1:0]         k;

  logic [GW-1:0]      g_eff;
  logic               wrap;
  logic               c_last;
  logic               r_last;
  logic [3:0]         en;
  logic               last_emit;
  logic [CW-1:0]      raddr;
  logic [CW-1:0]      waddr;
  logic               ram_we;
  line_entry_t        wentry;
  logic [$bits(line_entry_t)-1:0] rdata;
  logic               norm_start;
  vec18_t             norm_in;
  logic               norm_done;
  vec16_t             norm_out;
  vec18_t             v1;
  vec18_t             v2;
  vec18_t             em_vec;
  logic [CW-1:0]      em_row;
  logic [CW-1:0]      em_col;
  logic               out_load;
  vec18_t             zero_vec;
  vec16_t             unit_y;
  vec18_t             both;

  // Effective grid size, clamped to the supported range.
  always_comb begin
    if (side_len < 9'd2) begin
      g_eff = GW'(2);
    end else if (32'(side_len) > 32'(GRID_MAX)) begin
      g_eff = GW'(GRID_MAX);
    end else begin
      g_eff = GW'(side_len);
    end
  end

  assign wrap   = ({1'b0, row_count} >= g_eff) || ({1'b0, col_count} >= g_eff);
  assign c_last = {1'b0, c} == (g_eff - GW'(1));
  assign r_last = {1'b0, r} == (g_eff - GW'(1));

  assign zero_vec = '0;
  assign unit_y   = '{x: 16'sd0, y: UNIT_Q14, z: 16'sd0};

  // Triangle vectors of the current cell.
  assign v1.x = 18'(d0.height) - 18'(d1.height);
  assign v1.y = {2'b00, grid_spacing};
  assign v1.z = 18'(d0.height) - 18'(left_height);
  assign v2.x = 18'(left_height) - 18'(h);
  assign v2.y = {2'b00, grid_spacing};
  assign v2.z = 18'(d1.height) - 18'(h);

  // Vertices finished by this height, in emission order.
  assign en = {r_last && c_last, r_last, c_last, 1'b1};
  assign last_emit = (en >> (3'(k) + 3'd1)) == 4'd0;

  always_comb begin
    case (k)
      2'd0: begin
        em_vec = tl;
        em_row = r - CW'(1);
        em_col = c - CW'(1);
      end
      2'd1: begin
        em_vec = tr;
        em_row = r - CW'(1);
        em_col = c;
      end
      2'd2: begin
        em_vec = bl;
        em_row = r;
        em_col = c - CW'(1);
      end
      default: begin
        em_vec = br;
        em_row = r;
        em_col = c;
      end
    endcase
  end

  // Line store: height of the row above and the pending normal sums.
  assign raddr  = (state == S_RD0) ? (c - CW'(1)) : c;
  assign ram_we = (state == S_WR0) || (state == S_WR1);
  assign waddr  = (state == S_WR0) ? (c - CW'(1)) : c;

  always_comb begin
    if (state == S_WR0) begin
      wentry.height = left_height;
      wentry.sum    = bl;
    end else begin
      wentry.height = c_last ? h : d1.height;
      wentry.sum    = c_last ? br : tr;
    end
  end

  hsn_ram #(
    .WIDTH ($bits(line_entry_t)),
    .DEPTH (GRID_MAX)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wentry),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Shared normalizer.
  always_comb begin
    norm_start = 1'b0;
    norm_in    = em_vec;
    case (state)
      S_TRI: begin
        norm_start = (r != '0) && (grid_spacing != '0);
        norm_in    = v1;
      end
      S_N2S: begin
        norm_start = 1'b1;
        norm_in    = v2;
      end
      S_EM_SEL: begin
        norm_start = en[k];
      end
      default: norm_start = 1'b0;
    endcase
  end

  hsn_norm u_norm (
    .clk     (clk),
    .rst     (rst),
    .start   (norm_start),
    .vec_in  (norm_in),
    .done    (norm_done),
    .vec_out (norm_out)
  );

  assign s_tready = (state == S_IDLE) && !rst;
  assign out_load = (state == S_EM_OUT) && (!m_tvalid || m_tready);
  assign both     = add_vec(widen(n1), widen(n2));

  // Sequencer, configuration and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      side_len     <= 9'd256;
      grid_spacing <= 16'd256;
      row_count    <= '0;
      col_count    <= '0;
      left_height  <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_GRID_SIZE) begin
          side_len  <= cfg_data[8:0];
          row_count <= '0;
          col_count <= '0;
        end else begin
          grid_spacing <= cfg_data;
        end
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {norm_out.z, norm_out.y, norm_out.x, 8'(em_col), 8'(em_row)};
        m_tlast  <= last_emit;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            h     <= s_tdata;
            r     <= wrap ? '0 : row_count;
            c     <= wrap ? '0 : col_count;
            state <= (!wrap && col_count != '0) ? S_RD0 : S_FIN;
          end
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin
          d0    <= rdata;
          state <= S_RD2;
        end
        S_RD2: begin
          d1    <= rdata;
          state <= S_TRI;
        end
        S_TRI: begin
          if (r == '0) begin
            state <= S_WR0;
          end else if (grid_spacing == '0) begin
            n1    <= unit_y;
            n2    <= unit_y;
            state <= S_SUM;
          end else begin
            state <= S_N1W;
          end
        end
        S_N1W: begin
          if (norm_done) begin
            n1    <= norm_out;
            state <= S_N2S;
          end
        end
        S_N2S: state <= S_N2W;
        S_N2W: begin
          if (norm_done) begin
            n2    <= norm_out;
            state <= S_SUM;
          end
        end
        S_SUM: begin
          tl    <= add_vec((r == CW'(1) && c == CW'(1)) ? zero_vec : d0.sum, widen(n1));
          tr    <= add_vec((r == CW'(1)) ? zero_vec : d1.sum, both);
          bl    <= add_vec((c == CW'(1)) ? zero_vec : lower, both);
          br    <= widen(n2);
          state <= S_WR0;
        end
        S_WR0: state <= S_WR1;
        S_WR1: begin
          lower <= br;
          k     <= 2'd0;
          state <= (r != '0) ? S_EM_SEL : S_FIN;
        end
        S_EM_SEL: begin
          if (en[k]) begin
            state <= S_EM_WAIT;
          end else if (k == 2'd3) begin
            state <= S_FIN;
          end else begin
            k <= k + 2'd1;
          end
        end
        S_EM_WAIT: begin
          if (norm_done) begin
            state <= S_EM_OUT;
          end
        end
        S_EM_OUT: begin
          if (out_load) begin
            if (last_emit) begin
              state <= S_FIN;
            end else begin
              k     <= k + 2'd1;
              state <= S_EM_SEL;
            end
          end
        end
        S_FIN: begin
          left_height <= h;
          if (c_last) begin
            col_count <= '0;
            row_count <= r_last ? '0 : r + CW'(1);
          end else begin
            col_count <= c + CW'(1);
            row_count <= r;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The line store is only written while a height is being processed.
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !ram_we)
    else $error("line store written while idle");

  // A result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("pending result overwritten");

  // An accepted height always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state != S_IDLE))
    else $error("accepted height not processed");

  // The normalizer is started only where a state that waits for it follows.
  a_start_wait: assert property (@(posedge clk) disable iff (rst)
    norm_start |=> (state == S_N1W || state == S_N2W || state == S_EM_WAIT))
    else $error("normalizer started without a waiting state");

endmodule

@@ dv/heightmap_smooth_normals_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightmap_smooth_normals_test
// Streams height grids of several sizes and spacings through the block and
// checks every emitted vertex normal against a cycle-free software predictor
// kept in a scoreboard class.
// ----------------------------------------------------------------------------
module heightmap_smooth_normals_test
  import hsn_pkg::*;
;

  localparam int GRID_LIMIT = 256;
  localparam int IDLE_LIMIT = 20000;
  localparam int LONG_HOLD = 3000;

  typedef struct {
    int x;
    int y;
    int z;
  } ivec_t;

  typedef struct {
    logic [7:0]  row;
    logic [7:0]  col;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic        last;
  } normal_word_t;

  // Predictor of the block plus the queue of normals still due.
  class normal_scoreboard;
    int unsigned side_len = 256;
    int unsigned spacing = 256;
    int prev_heights[GRID_LIMIT];
    ivec_t upper_sums[GRID_LIMIT];
    ivec_t lower_sums[GRID_LIMIT];
    int left_h = 0;
    int unsigned row_pos = 0;
    int unsigned col_pos = 0;
    normal_word_t due[$];
    int errors = 0;

    function void write_reg(logic index, logic [15:0] value);
      if (index == CFG_GRID_SIZE) begin
        side_len = value[8:0];
        row_pos = 0;
        col_pos = 0;
      end else begin
        spacing = value;
      end
    endfunction

    function longint unsigned root(longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function int scale_comp(longint v, longint unsigned q);
      longint unsigned mag;
      mag = (v < 0) ? -v : v;
      mag = (((mag << 28) / q) + 1) >> 1;
      if (mag > 16384) mag = 16384;
      return (v < 0) ? -int'(mag) : int'(mag);
    endfunction

    function ivec_t unit(longint x, longint y, longint z);
      ivec_t o;
      longint unsigned l2;
      longint unsigned q;
      l2 = x * x + y * y + z * z;
      if (l2 == 0) begin
        o.x = 0;
        o.y = 16384;
        o.z = 0;
        return o;
      end
      q = root(l2 << 26);
      o.x = scale_comp(x, q);
      o.y = scale_comp(y, q);
      o.z = scale_comp(z, q);
      return o;
    endfunction

    function ivec_t add(ivec_t a, ivec_t b);
      a.x += b.x;
      a.y += b.y;
      a.z += b.z;
      return a;
    endfunction

    function void push_normal(int unsigned r, int unsigned c, ivec_t sum);
      normal_word_t w;
      ivec_t n;
      n = unit(sum.x, sum.y, sum.z);
      w.row = r[7:0];
      w.col = c[7:0];
      w.nx = n.x[15:0];
      w.ny = n.y[15:0];
      w.nz = n.z[15:0];
      w.last = 1'b0;
      due.insert(due.size(), w);
    endfunction

    // Work out the normals finished by one accepted height word.
    function void note_height(logic [15:0] word);
      int unsigned g;
      int unsigned r;
      int unsigned c;
      int h;
      int emitted;
      ivec_t n1, n2, both, tl, tr, bl, br, zero;
      g = side_len;
      if (g < 2) g = 2;
      if (g > GRID_LIMIT) g = GRID_LIMIT;
      if (row_pos >= g || col_pos >= g) begin
        row_pos = 0;
        col_pos = 0;
      end
      r = row_pos;
      c = col_pos;
      h = $signed(word);
      emitted = 0;
      zero = '{0, 0, 0};
      if (r >= 1 && c >= 1) begin
        if (spacing == 0) begin
          n1 = '{0, 16384, 0};
          n2 = n1;
        end else begin
          n1 = unit(prev_heights[c-1] - prev_heights[c], spacing,
                    prev_heights[c-1] - left_h);
          n2 = unit(left_h - h, spacing, prev_heights[c] - h);
        end
        both = add(n1, n2);
        tl = (r == 1 && c == 1) ? zero : upper_sums[c-1];
        tr = (r == 1) ? zero : upper_sums[c];
        bl = (c == 1) ? zero : lower_sums[c-1];
        tl = add(tl, n1);
        tr = add(tr, both);
        bl = add(bl, both);
        br = n2;
        push_normal(r - 1, c - 1, tl);
        emitted++;
        upper_sums[c-1] = bl;
        upper_sums[c] = tr;
        lower_sums[c-1] = bl;
        lower_sums[c] = br;
        if (c == g - 1) begin
          push_normal(r - 1, c, tr);
          emitted++;
          upper_sums[c] = br;
        end
        if (r == g - 1) begin
          push_normal(r, c - 1, bl);
          emitted++;
          if (c == g - 1) begin
            push_normal(r, c, br);
            emitted++;
          end
        end
      end
      if (c >= 1) prev_heights[c-1] = left_h;
      if (c == g - 1) prev_heights[c] = h;
      left_h = h;
      if (c + 1 >= g) begin
        col_pos = 0;
        row_pos = (r + 1 >= g) ? 0 : r + 1;
      end else begin
        col_pos = c + 1;
      end
      if (emitted > 0) due[$].last = 1'b1;
    endfunction

    function void check_normal(logic [63:0] data, logic last);
      normal_word_t e;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected normal word %h last %b", data, last);
        return;
      end
      e = due.pop_front();
      if (data !== {e.nz, e.ny, e.nx, e.col, e.row} || last !== e.last) begin
        errors++;
        if (errors <= 10)
          $display("normal (%0d,%0d): expected %0d %0d %0d last %b, got %0d,%0d %0d %0d %0d last %b",
                   e.row, e.col, $signed(e.nx), $signed(e.ny), $signed(e.nz), e.last,
                   data[7:0], data[15:8], $signed(data[31:16]), $signed(data[47:32]),
                   $signed(data[63:48]), last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // height
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;        // vertex_row, vertex_col, normal_x, normal_y, normal_z
  logic        m_tlast;        // last

  normal_scoreboard sb = new();
  bit hold_request = 1'b0;
  int idle_cycles = 0;
  int random_items = 0;

  heightmap_smooth_normals i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Monitor both handshakes and keep the watchdog fed.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_height(s_tdata);
      if (m_tvalid && m_tready) sb.check_normal(m_tdata, m_tlast);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Receiver: ready runs, random stalls, and one long hold-off on request.
  initial begin
    int len;
    int mode;
    @(negedge rst);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        @(posedge clk) m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      mode = $urandom_range(0, 2);
      len = $urandom_range(1, 40);
      repeat (len) begin
        @(posedge clk);
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic logic [15:0] pick_height(int base);
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2, 3: return 16'($urandom());
      default: return 16'(base + $urandom_range(0, 1024) - 512);
    endcase
  endfunction

  task automatic write_reg(logic index, logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    sb.write_reg(index, value);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every due normal has left, then let a height with no normals finish.
  task automatic wait_drained();
    while (sb.due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Send heights in bursts with random gaps; a word stays valid until it is taken.
  task automatic send_heights(int count, bit fixed, logic [15:0] value);
    int burst;
    int base;
    burst = $urandom_range(1, 12);
    base = $signed(16'($urandom()));
    @(posedge clk);
    for (int k = 0; k < count; k++) begin
      s_tvalid <= 1'b1;
      s_tdata <= fixed ? value : pick_height(base);
      @(posedge clk);
      while (!s_tready) @(posedge clk);
      burst--;
      if (burst == 0 || k == count - 1) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
        burst = $urandom_range(1, 12);
      end
    end
  endtask

  task automatic send_list(logic [15:0] values[$]);
    foreach (values[k]) send_heights(1, 1'b1, values[k]);
  endtask

  initial begin
    int g;
    int n;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Default size: part of the first row of a full-width grid.
    send_heights(20, 1'b0, 0);
    wait_drained();

    // Smallest grid with extreme heights, then a flat one.
    write_reg(CFG_GRID_SIZE, 16'd2);
    send_list('{16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h0, 16'h0, 16'h0, 16'h0});
    wait_drained();

    // Zero spacing on a 3x3 grid.
    write_reg(CFG_GRID_SIZE, 16'd3);
    write_reg(CFG_GRID_SPACING, 16'd0);
    send_heights(9, 1'b0, 0);
    wait_drained();

    // Size below range acts as two; largest and smallest spacing.
    write_reg(CFG_GRID_SIZE, 16'd0);
    write_reg(CFG_GRID_SPACING, 16'hffff);
    send_heights(8, 1'b0, 0);
    wait_drained();
    write_reg(CFG_GRID_SIZE, 16'd1);
    write_reg(CFG_GRID_SPACING, 16'd1);
    send_list('{16'h8000, 16'h7fff, 16'h7fff, 16'h8000});
    wait_drained();

    // Long receiver hold-off while heights keep coming.
    write_reg(CFG_GRID_SIZE, 16'd4);
    write_reg(CFG_GRID_SPACING, 16'(($urandom_range(1, 65535))));
    hold_request = 1'b1;
    send_heights(16, 1'b0, 0);
    wait_drained();

    // Spacing change in the middle of a frame.
    write_reg(CFG_GRID_SIZE, 16'd5);
    send_heights(12, 1'b0, 0);
    wait_drained();
    write_reg(CFG_GRID_SPACING, 16'(($urandom_range(1, 65535))));
    send_heights(13, 1'b0, 0);
    wait_drained();

    // Size above range acts as the maximum: part of a first row.
    write_reg(CFG_GRID_SIZE, 16'h01ff);
    write_reg(CFG_GRID_SPACING, 16'hffff);
    send_heights(10, 1'b0, 0);
    wait_drained();

    // Random small grids and spacings.
    while (random_items < 60) begin
      if ($urandom_range(0, 3) != 0) begin
        g = $urandom_range(2, 6);
        write_reg(CFG_GRID_SIZE, 16'(g));
      end
      case ($urandom_range(0, 5))
        0: write_reg(CFG_GRID_SPACING, 16'd1);
        1: write_reg(CFG_GRID_SPACING, 16'hffff);
        2: write_reg(CFG_GRID_SPACING, 16'd0);
        default: write_reg(CFG_GRID_SPACING, 16'($urandom_range(1, 2048)));
      endcase
      n = $urandom_range(4, 24);
      send_heights(n, 1'b0, 0);
      random_items += n;
      wait_drained();
    end

    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
